// File: hdl/spe_pkg.sv
// Shared types and constants of the shuffle permutation engine.
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;

  localparam int CommandWidth = 2;
  localparam int CountWidth   = 11;
  localparam int RandomWidth  = 32;
  localparam int ItemWidth    = 10;
  localparam int StatusWidth  = 2;
  localparam int TotalWidth   = 11;

  localparam logic [CommandWidth-1:0] CMD_DRAW    = 2'd0;
  localparam logic [CommandWidth-1:0] CMD_ADD     = 2'd1;
  localparam logic [CommandWidth-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CommandWidth-1:0] CMD_RESTART = 2'd3;

  localparam logic [StatusWidth-1:0] ST_OK      = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY   = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL    = 2'd2;
  localparam logic [StatusWidth-1:0] ST_TOOMANY = 2'd3;

  typedef struct packed {
    logic [CommandWidth-1:0] command;
    logic [CountWidth-1:0]   count;
    logic [RandomWidth-1:0]  random_word;
  } cmd_t;

  typedef struct packed {
    logic [ItemWidth-1:0]   drawn_item;
    logic [StatusWidth-1:0] status;
    logic [TotalWidth-1:0]  item_total;
    logic                   cycle_done;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/spe_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface spe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/spe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module spe_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/shuffle_permutation_engine_top.sv
// Top level of the shuffle permutation engine: control sequencer, divider and pool memory.
//
// The cmd channel takes one command per transaction (draw, add, remove, restart);
// the res channel returns exactly one result per command, in order.
// The pool of item numbers lives in one RAM of DEPTH entries with a registered read.
// A draw steps from the accept through a setup state, a one-bit-per-cycle restoring
// divider that reduces the random word modulo the pool size, the RAM steps (read the
// chosen entry, read the last entry, write it back) and the load of the result
// register. A draw on an empty pool first refills it from the item count; with no
// items it returns ST_EMPTY. Add, remove, restart and the refill write one RAM
// entry per cycle (up to DEPTH entries). Rejected commands and commands that
// write nothing go straight from the accept to loading the result register.
// One command is worked on at a time; the next is accepted while the previous
// result still waits in the output register, and its result is held back until
// that register is free. A stalled receiver therefore stalls the block after one
// more command. Reset empties the pool and clears the item count; the pool RAM
// itself needs no clearing, since only entries written since then are read.
`timescale 1ns / 1ps
`default_nettype none
module shuffle_permutation_engine_top #(
  parameter int DEPTH = 1024
) (
  input wire logic   clk,
  input wire logic   rst,
  spe_stream_if.sink   cmd,
  spe_stream_if.source res
);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int SW = ((PW > spe_pkg::CountWidth) ? PW : spe_pkg::CountWidth) + 1;
  localparam int RW = spe_pkg::RandomWidth;
  localparam int CW = $clog2(RW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_DSET  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RDI   = 3'd4;
  localparam logic [2:0] S_RDL   = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                       state;
  logic [PW-1:0]                    pool_end;
  logic [PW-1:0]                    total;
  logic [spe_pkg::CommandWidth-1:0] op;
  logic [RW-1:0]                    rnd;
  logic [spe_pkg::StatusWidth-1:0]  status;
  logic [IW-1:0]                    drawn;
  logic [IW-1:0]                    sw_base;
  logic [IW-1:0]                    sw_dbase;
  logic [PW-1:0]                    sw_len;
  logic [PW-1:0]                    sw_idx;
  logic [PW-1:0]                    dvs;
  logic [PW-1:0]                    rem;
  logic [CW-1:0]                    div_cnt;
  logic                             res_valid;
  spe_pkg::res_t                    res_payload;

  spe_pkg::cmd_t                    in_item;
  logic [SW-1:0]                    cnt_ext;
  logic [SW-1:0]                    end_ext;
  logic [SW-1:0]                    tot_ext;
  logic [PW:0]                      rem_shift;
  logic [PW:0]                      rem_sub;
  logic [PW-1:0]                    cut_end;
  logic                             out_free;

  logic                             ram_we;
  logic [IW-1:0]                    ram_waddr;
  logic [IW-1:0]                    ram_wdata;
  logic [IW-1:0]                    ram_raddr;
  logic [IW-1:0]                    ram_rdata;

  spe_ram #(
    .WIDTH(IW),
    .DEPTH(DEPTH)
  ) u_pool (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_item   = cmd.payload;
  assign cmd.ready = (state == S_IDLE);
  assign res.valid   = res_valid;
  assign res.payload = res_payload;
  assign out_free  = !res_valid || res.ready;

  assign cnt_ext   = SW'(in_item.count);
  assign end_ext   = SW'(pool_end);
  assign tot_ext   = SW'(total);
  assign cut_end   = (end_ext >= cnt_ext) ? PW'(end_ext - cnt_ext) : '0;

  assign rem_shift = {rem, rnd[RW-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IW'(sw_base + sw_idx[IW-1:0]);
    ram_wdata = IW'(sw_dbase + sw_idx[IW-1:0]);
    ram_raddr = pool_end[IW-1:0];
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end
    if (state == S_RDI) begin
      ram_raddr = rem[IW-1:0];
    end
    if (state == S_WR) begin
      ram_we    = 1'b1;
      ram_waddr = rem[IW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pool_end  <= '0;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op     <= in_item.command;
            rnd    <= in_item.random_word;
            drawn  <= '0;
            sw_idx <= '0;
            unique case (in_item.command)
              spe_pkg::CMD_DRAW: begin
                if (pool_end != '0) begin
                  status <= spe_pkg::ST_OK;
                  state  <= S_DSET;
                end else if (total == '0) begin
                  status <= spe_pkg::ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  status   <= spe_pkg::ST_OK;
                  pool_end <= total;
                  sw_base  <= '0;
                  sw_dbase <= '0;
                  sw_len   <= total;
                  state    <= S_FILL;
                end
              end
              spe_pkg::CMD_ADD: begin
                if (tot_ext + cnt_ext > SW'(DEPTH)) begin
                  status <= spe_pkg::ST_FULL;
                  state  <= S_DONE;
                end else if (in_item.count != '0) begin
                  status   <= spe_pkg::ST_OK;
                  pool_end <= pool_end + PW'(in_item.count);
                  total    <= total + PW'(in_item.count);
                  sw_base  <= pool_end[IW-1:0];
                  sw_dbase <= total[IW-1:0];
                  sw_len   <= PW'(in_item.count);
                  state    <= S_FILL;
                end else begin
                  status <= spe_pkg::ST_OK;
                  state  <= S_DONE;
                end
              end
              spe_pkg::CMD_REMOVE: begin
                if (cnt_ext > tot_ext) begin
                  status <= spe_pkg::ST_TOOMANY;
                  state  <= S_DONE;
                end else if (in_item.count != '0) begin
                  status   <= spe_pkg::ST_OK;
                  pool_end <= cut_end;
                  total    <= total - PW'(in_item.count);
                  sw_base  <= '0;
                  sw_dbase <= '0;
                  sw_len   <= cut_end;
                  state    <= (cut_end != '0) ? S_FILL : S_DONE;
                end else begin
                  status <= spe_pkg::ST_OK;
                  state  <= S_DONE;
                end
              end
              default: begin
                status   <= spe_pkg::ST_OK;
                pool_end <= total;
                sw_base  <= '0;
                sw_dbase <= '0;
                sw_len   <= total;
                state    <= (total != '0) ? S_FILL : S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          sw_idx <= sw_idx + 1'b1;
          if (sw_idx + 1'b1 == sw_len) begin
            state <= (op == spe_pkg::CMD_DRAW) ? S_DSET : S_DONE;
          end
        end
        S_DSET: begin
          dvs      <= pool_end;
          pool_end <= pool_end - 1'b1;
          rem      <= '0;
          div_cnt  <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_sub[PW] ? rem_shift[PW-1:0] : rem_sub[PW-1:0];
          rnd     <= {rnd[RW-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CW'(RW - 1)) begin
            state <= S_RDI;
          end
        end
        S_RDI: begin
          state <= S_RDL;
        end
        S_RDL: begin
          drawn <= ram_rdata;
          state <= S_WR;
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_valid              <= 1'b1;
            res_payload.drawn_item <= spe_pkg::ItemWidth'(drawn);
            res_payload.status     <= status;
            res_payload.item_total <= spe_pkg::TotalWidth'(total);
            res_payload.cycle_done <= (pool_end == '0);
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sim/spe_shuffle_checker.sv
// Checker for the shuffle permutation engine: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module spe_shuffle_checker #(
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  spe_pkg::cmd_t cmd_payload,
  input  logic          res_valid,
  input  logic          res_ready,
  input  spe_pkg::res_t res_payload,
  output int            mismatch_count,
  output int            pending_count,
  output int            checked_count
);

  logic [spe_pkg::ItemWidth-1:0] pool [DEPTH];
  int                            pool_end;
  int                            item_count;
  spe_pkg::res_t                 expected_results [$];

  function automatic void fill_identity(int n);
    int i;
    for (i = 0; i < n && i < DEPTH; i++) begin
      pool[i] = spe_pkg::ItemWidth'(i);
    end
  endfunction

  function automatic spe_pkg::res_t shuffle_step(spe_pkg::cmd_t c);
    spe_pkg::res_t                   r;
    logic [spe_pkg::StatusWidth-1:0] status;
    logic [31:0]                     slot;
    int                              n;
    int                              i;
    status = spe_pkg::ST_OK;
    r = '0;
    n = int'(c.count);
    case (c.command)
      spe_pkg::CMD_DRAW: begin
        if (pool_end == 0) begin
          if (item_count == 0) begin
            status = spe_pkg::ST_EMPTY;
          end else begin
            fill_identity(item_count);
            pool_end = item_count;
          end
        end
        if (status == spe_pkg::ST_OK) begin
          pool_end = pool_end - 1;
          slot = c.random_word % (32'(pool_end) + 32'd1);
          r.drawn_item = pool[slot];
          pool[slot] = pool[pool_end];
        end
      end
      spe_pkg::CMD_ADD: begin
        if (item_count + n > DEPTH) begin
          status = spe_pkg::ST_FULL;
        end else begin
          for (i = 0; i < n; i++) begin
            pool[pool_end + i] = spe_pkg::ItemWidth'(item_count + i);
          end
          pool_end = pool_end + n;
          item_count = item_count + n;
        end
      end
      spe_pkg::CMD_REMOVE: begin
        if (n > item_count) begin
          status = spe_pkg::ST_TOOMANY;
        end else if (n > 0) begin
          pool_end = (pool_end >= n) ? pool_end - n : 0;
          item_count = item_count - n;
          fill_identity(pool_end);
        end
      end
      default: begin
        fill_identity(item_count);
        pool_end = item_count;
      end
    endcase
    r.status = status;
    r.item_total = spe_pkg::TotalWidth'(item_count);
    r.cycle_done = (pool_end == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    spe_pkg::res_t exp_r;
    if (rst) begin
      pool_end = 0;
      item_count = 0;
      expected_results.delete();
      mismatch_count = 0;
      checked_count = 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(shuffle_step(cmd_payload));
      end
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding: %p", res_payload);
          mismatch_count++;
        end else begin
          exp_r = expected_results.pop_front();
          checked_count++;
          if (res_payload.drawn_item !== exp_r.drawn_item) begin
            $error("drawn_item mismatch: expected %0d, actual %0d",
                   exp_r.drawn_item, res_payload.drawn_item);
            mismatch_count++;
          end
          if (res_payload.status !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_r.status, res_payload.status);
            mismatch_count++;
          end
          if (res_payload.item_total !== exp_r.item_total) begin
            $error("item_total mismatch: expected %0d, actual %0d",
                   exp_r.item_total, res_payload.item_total);
            mismatch_count++;
          end
          if (res_payload.cycle_done !== exp_r.cycle_done) begin
            $error("cycle_done mismatch: expected %0d, actual %0d",
                   exp_r.cycle_done, res_payload.cycle_done);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the shuffle permutation engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH        = 1024;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   pending_count;
  int   checked_count;
  int   items_sent;
  int   draws_sent;
  int   cycle_count;
  bit   hold_taken;
  wire  quiet = (items_sent >= 260) && (items_sent < 330);

  spe_stream_if #(.payload_t(spe_pkg::cmd_t)) cmd_ch ();
  spe_stream_if #(.payload_t(spe_pkg::res_t)) res_ch ();

  shuffle_permutation_engine_top #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  spe_shuffle_checker #(.DEPTH(DEPTH)) checker_inst (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_ch.valid),
    .cmd_ready      (cmd_ch.ready),
    .cmd_payload    (cmd_ch.payload),
    .res_valid      (res_ch.valid),
    .res_ready      (res_ch.ready),
    .res_payload    (res_ch.payload),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** shuffle_permutation_engine_top: FAILED **");
    $finish;
  end

  initial begin
    res_ch.ready <= 1'b0;
    hold_taken = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_taken && items_sent >= 150) begin
        hold_taken = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= quiet || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  task automatic issue(input logic [spe_pkg::CommandWidth-1:0] op, input int n,
                       input logic [spe_pkg::RandomWidth-1:0] word);
    spe_pkg::cmd_t c;
    c.command = op;
    c.count = spe_pkg::CountWidth'(n);
    c.random_word = word;
    while (!quiet && $urandom_range(0, 99) < 35) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    if (op == spe_pkg::CMD_DRAW) draws_sent++;
  endtask

  function automatic int any_count();
    return $urandom_range(0, 1024);
  endfunction

  initial begin
    int i;
    int pick;
    items_sent = 0;
    draws_sent = 0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(spe_pkg::CMD_DRAW, any_count(), $urandom());
    issue(spe_pkg::CMD_REMOVE, 1, $urandom());
    issue(spe_pkg::CMD_REMOVE, 0, $urandom());
    issue(spe_pkg::CMD_ADD, 0, $urandom());
    issue(spe_pkg::CMD_RESTART, any_count(), $urandom());
    issue(spe_pkg::CMD_ADD, 1024, $urandom());
    issue(spe_pkg::CMD_ADD, 1, $urandom());
    issue(spe_pkg::CMD_DRAW, any_count(), 32'hFFFF_FFFF);
    issue(spe_pkg::CMD_DRAW, any_count(), 32'h0000_0000);
    issue(spe_pkg::CMD_REMOVE, 1024, $urandom());
    issue(spe_pkg::CMD_ADD, 3, $urandom());
    for (i = 0; i < 4; i++) issue(spe_pkg::CMD_DRAW, any_count(), $urandom());
    issue(spe_pkg::CMD_RESTART, any_count(), $urandom());
    issue(spe_pkg::CMD_REMOVE, 5, $urandom());
    issue(spe_pkg::CMD_REMOVE, 2, $urandom());
    issue(spe_pkg::CMD_DRAW, any_count(), 32'hFFFF_FFFF);
    issue(spe_pkg::CMD_DRAW, any_count(), $urandom());
    issue(spe_pkg::CMD_ADD, 1023, $urandom());
    issue(spe_pkg::CMD_ADD, 2, $urandom());
    issue(spe_pkg::CMD_REMOVE, 1023, $urandom());
    issue(spe_pkg::CMD_DRAW, any_count(), $urandom());

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        issue(spe_pkg::CMD_DRAW, any_count(), $urandom());
      end else if (pick < 70) begin
        issue(spe_pkg::CMD_ADD, $urandom_range(0, 6), $urandom());
      end else if (pick < 85) begin
        issue(spe_pkg::CMD_REMOVE, $urandom_range(0, 8), $urandom());
      end else if (pick < 91) begin
        issue(spe_pkg::CMD_RESTART, any_count(), $urandom());
      end else if (pick < 93) begin
        issue(spe_pkg::CMD_ADD, any_count(), $urandom());
      end else if (pick < 96) begin
        issue(spe_pkg::CMD_REMOVE, any_count(), $urandom());
      end else begin
        issue(spe_pkg::CMD_DRAW, any_count(),
              ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0);
      end
    end
    cmd_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run issued %0d commands (%0d draws) and checked %0d results in %0d cycles.",
             items_sent, draws_sent, checked_count, cycle_count);
    $display("Covered empty draws, capacity and remove errors, refills and a long output stall.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** shuffle_permutation_engine_top: PASSED **");
    end else begin
      $display("** shuffle_permutation_engine_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: shuffle_permutation_engine_top.f
hdl/spe_pkg.sv
hdl/spe_stream_if.sv
hdl/spe_ram.sv
hdl/shuffle_permutation_engine_top.sv
sim/spe_shuffle_checker.sv
sim/tb_top.sv
